// File: rtl/fae_pkg.sv
// ----------------------------------------------------------------------------
// fae_pkg
// Shared widths, register indexes and controller/datapath bundles for the
// even/odd frame averager.
// ----------------------------------------------------------------------------
package fae_pkg;

  // field widths
  localparam int PIX_W     = 8;
  localparam int IDX_W     = 16;
  localparam int AVG_W     = 8;
  localparam int SUM_W     = 16;
  localparam int FRM_W     = 8;
  localparam int TOT_W     = 9;
  localparam int NPX_W     = 17;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;        // latch input transaction, issue sum read
    logic accum;       // add and write back, issue other-plane read
    logic grab_other;  // capture other-plane sum
    logic div_start;   // load the divider for the current plane
    logic out_load;    // load the result register
    logic plane;       // plane being averaged
  } fae_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last_frame;  // current pixel belongs to the last frame
    logic two_planes;  // split mode with at least two frames
    logic div_busy;    // divider still iterating
  } fae_status_t;

  // one result transaction
  typedef struct packed {
    logic             plane;
    logic [IDX_W-1:0] pixel_index;
    logic [AVG_W-1:0] average;
    logic             run_last;
    logic             image_done;
  } fae_result_t;

endpackage

// File: rtl/fae_if.sv
// ----------------------------------------------------------------------------
// fae_if
// Valid/ready channels for pixel input and average results.
// ----------------------------------------------------------------------------
interface fae_pixel_if;
  logic                     valid;
  logic                     ready;
  logic [fae_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface fae_result_if;
  logic                      valid;
  logic                      ready;
  logic                      plane;
  logic [fae_pkg::IDX_W-1:0] pixel_index;
  logic [fae_pkg::AVG_W-1:0] average;
  logic                      run_last;
  logic                      image_done;

  modport source (output valid, output plane, output pixel_index, output average,
                  output run_last, output image_done, input ready);
  modport sink   (input valid, input plane, input pixel_index, input average,
                  input run_last, input image_done, output ready);
endinterface

// File: rtl/fae_ram.sv
// ----------------------------------------------------------------------------
// fae_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fae_div.sv
// ----------------------------------------------------------------------------
// fae_div
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// eight bits, so only the low eight dividend bits are iterated.
// ----------------------------------------------------------------------------
module fae_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fae_pkg::SUM_W-1:0]   dividend,
  input  logic [fae_pkg::TOT_W-1:0]   divisor,
  output logic                        busy,
  output logic [fae_pkg::AVG_W-1:0]   quotient
);

  logic [fae_pkg::TOT_W-1:0] rem;
  logic [fae_pkg::TOT_W-1:0] dsr;
  logic [fae_pkg::AVG_W-1:0] low;
  logic [2:0]                cnt;
  logic [fae_pkg::TOT_W:0]   shifted;
  logic                      ge;

  // trial subtraction
  assign shifted = {rem, low[fae_pkg::AVG_W-1]};
  assign ge      = (shifted >= {1'b0, dsr});

  // iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 3'd7;
    end else if (busy) begin
      cnt <= cnt - 3'd1;
      if (cnt == 3'd0) begin
        busy <= 1'b0;
      end
    end
  end

  // operand and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend[fae_pkg::SUM_W-1:fae_pkg::AVG_W]};
      low      <= dividend[fae_pkg::AVG_W-1:0];
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? fae_pkg::TOT_W'(shifted - {1'b0, dsr}) : shifted[fae_pkg::TOT_W-1:0];
      low      <= {low[fae_pkg::AVG_W-2:0], 1'b0};
      quotient <= {quotient[fae_pkg::AVG_W-2:0], ge};
    end
  end

endmodule

// File: rtl/fae_datapath.sv
// ----------------------------------------------------------------------------
// fae_datapath
// Configuration registers, pixel/frame counters, sum memory with
// read-modify-write, plane divider and result register.
// ----------------------------------------------------------------------------
module fae_datapath #(
  parameter int MAX_PIXELS = 65536,
  parameter int MAX_FRAMES = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fae_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fae_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [fae_pkg::PIX_W-1:0]        pixel,
  input  fae_pkg::fae_cmd_t                cmd,
  output fae_pkg::fae_status_t             status,
  output fae_pkg::fae_result_t             result
);

  localparam int PIX_CAP = (MAX_PIXELS < 65536) ? MAX_PIXELS : 65536;
  localparam int FRM_CAP = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
  localparam int DEPTH   = 2 * MAX_PIXELS;
  localparam int ADDR_W  = $clog2(DEPTH);

  // configuration, stored already clamped to the usable range
  logic                      split;
  logic [fae_pkg::TOT_W-1:0] tot;
  logic [fae_pkg::NPX_W-1:0] npx;

  // position counters
  logic [fae_pkg::IDX_W-1:0] pos;
  logic [fae_pkg::FRM_W-1:0] frm;

  // per-transaction registers
  logic [fae_pkg::PIX_W-1:0] pix_q;
  logic [fae_pkg::IDX_W-1:0] pos_q;
  logic                      first_q;
  logic                      last_frame_q;
  logic                      last_pixel_q;
  logic                      odd_q;
  logic [ADDR_W-1:0]         slot_q;
  logic [ADDR_W-1:0]         other_q;
  logic [fae_pkg::SUM_W-1:0] sum_cur;
  logic [fae_pkg::SUM_W-1:0] sum_oth;

  // counter-derived values
  logic [fae_pkg::IDX_W-1:0] pos_eff;
  logic [fae_pkg::FRM_W-1:0] frm_eff;
  logic [fae_pkg::NPX_W-1:0] pos_inc;
  logic [fae_pkg::TOT_W-1:0] frm_inc;
  logic                      wrap;
  logic                      last_frame;
  logic                      odd_now;
  logic                      first_now;
  logic [ADDR_W-1:0]         even_addr;
  logic [ADDR_W-1:0]         odd_addr;
  logic [ADDR_W-1:0]         slot_now;
  logic [ADDR_W-1:0]         other_now;

  // memory and arithmetic
  logic [ADDR_W-1:0]         raddr;
  logic [fae_pkg::SUM_W-1:0] rdata;
  logic [fae_pkg::SUM_W-1:0] sum_new;
  logic [fae_pkg::SUM_W-1:0] div_dividend;
  logic [fae_pkg::TOT_W-1:0] div_divisor;
  logic [fae_pkg::TOT_W:0]   tot_plus;
  logic [fae_pkg::AVG_W-1:0] quotient;
  logic                      div_busy;
  logic                      two_planes;
  logic                      run_last;

  // config clamp and counter restart
  always_ff @(posedge clk) begin
    if (rst) begin
      split <= 1'b0;
      tot   <= fae_pkg::TOT_W'(1);
      npx   <= fae_pkg::NPX_W'(PIX_CAP);
      pos   <= '0;
      frm   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fae_pkg::REG_SPLIT_MODE: begin
          split <= cfg_data[0];
          pos   <= '0;
          frm   <= '0;
        end
        fae_pkg::REG_FRAME_TOTAL: begin
          if (cfg_data[fae_pkg::TOT_W-1:0] == '0) begin
            tot <= fae_pkg::TOT_W'(1);
          end else if (cfg_data[fae_pkg::TOT_W-1:0] > fae_pkg::TOT_W'(FRM_CAP)) begin
            tot <= fae_pkg::TOT_W'(FRM_CAP);
          end else begin
            tot <= cfg_data[fae_pkg::TOT_W-1:0];
          end
          pos <= '0;
          frm <= '0;
        end
        fae_pkg::REG_FRAME_PIXELS: begin
          if (cfg_data[fae_pkg::NPX_W-1:0] == '0) begin
            npx <= fae_pkg::NPX_W'(1);
          end else if (cfg_data[fae_pkg::NPX_W-1:0] > fae_pkg::NPX_W'(PIX_CAP)) begin
            npx <= fae_pkg::NPX_W'(PIX_CAP);
          end else begin
            npx <= cfg_data[fae_pkg::NPX_W-1:0];
          end
          pos <= '0;
          frm <= '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.take) begin
      pos <= wrap ? '0 : pos_inc[fae_pkg::IDX_W-1:0];
      if (wrap) begin
        frm <= last_frame ? '0 : frm_inc[fae_pkg::FRM_W-1:0];
      end
    end
  end

  // position decode for the incoming pixel
  always_comb begin
    pos_eff    = ({1'b0, pos} >= npx) ? '0 : pos;
    frm_eff    = ({1'b0, frm} >= tot) ? '0 : frm;
    pos_inc    = {1'b0, pos_eff} + fae_pkg::NPX_W'(1);
    frm_inc    = {1'b0, frm_eff} + fae_pkg::TOT_W'(1);
    wrap       = (pos_inc == npx);
    last_frame = (frm_inc == tot);
    odd_now    = split & frm_eff[0];
    first_now  = split ? (frm_eff < fae_pkg::FRM_W'(2)) : (frm_eff == '0);
    even_addr  = ADDR_W'(pos_eff);
    odd_addr   = ADDR_W'(MAX_PIXELS) + ADDR_W'(pos_eff);
    slot_now   = odd_now ? odd_addr : even_addr;
    other_now  = odd_now ? even_addr : odd_addr;
  end

  // capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pix_q        <= pixel;
      pos_q        <= pos_eff;
      first_q      <= first_now;
      last_frame_q <= last_frame;
      last_pixel_q <= wrap;
      odd_q        <= odd_now;
      slot_q       <= slot_now;
      other_q      <= other_now;
    end
  end

  // sum memory: read on take, other plane read during accumulate
  assign raddr   = cmd.take ? slot_now : other_q;
  assign sum_new = first_q ? fae_pkg::SUM_W'(pix_q) : rdata + fae_pkg::SUM_W'(pix_q);

  fae_ram #(
    .WIDTH (fae_pkg::SUM_W),
    .DEPTH (DEPTH)
  ) u_sums (
    .clk   (clk),
    .we    (cmd.accum),
    .waddr (slot_q),
    .wdata (sum_new),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sum holding registers
  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      sum_cur <= sum_new;
    end
    if (cmd.grab_other) begin
      sum_oth <= rdata;
    end
  end

  // divider operand select per plane
  always_comb begin
    tot_plus     = {1'b0, tot} + (fae_pkg::TOT_W+1)'(1);
    div_dividend = (cmd.plane == odd_q) ? sum_cur : sum_oth;
    if (!split) begin
      div_divisor = tot;
    end else if (cmd.plane) begin
      div_divisor = {1'b0, tot[fae_pkg::TOT_W-1:1]};
    end else begin
      div_divisor = tot_plus[fae_pkg::TOT_W:1];
    end
  end

  fae_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // result register
  assign two_planes = split & (tot[fae_pkg::TOT_W-1:1] != '0);
  assign run_last   = !(!cmd.plane && two_planes);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.plane       <= cmd.plane;
      result.pixel_index <= pos_q;
      result.average     <= quotient;
      result.run_last    <= run_last;
      result.image_done  <= run_last & last_pixel_q;
    end
  end

  assign status.last_frame = last_frame_q;
  assign status.two_planes = two_planes;
  assign status.div_busy   = div_busy;

endmodule

// File: rtl/fae_ctrl.sv
// ----------------------------------------------------------------------------
// fae_ctrl
// Sequencer: accept a pixel, accumulate, and on the last frame run the
// divider once per plane and hand each average out.
// ----------------------------------------------------------------------------
module fae_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  fae_pkg::fae_status_t  status,
  output fae_pkg::fae_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_OTHER,
    S_START,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;
  logic   plane;

  // command decode
  always_comb begin
    cmd       = '0;
    cmd.plane = plane;
    unique case (state)
      S_IDLE:  cmd.take       = in_valid & in_ready;
      S_ACC:   cmd.accum      = 1'b1;
      S_OTHER: cmd.grab_other = 1'b1;
      S_START: cmd.div_start  = 1'b1;
      S_DIV:   cmd.out_load   = !status.div_busy;
      S_OUT:   ;
      default: ;
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
      plane     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_ACC;
            in_ready <= 1'b0;
          end
        end
        S_ACC: begin
          plane <= 1'b0;
          if (!status.last_frame) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end else if (status.two_planes) begin
            state <= S_OTHER;
          end else begin
            state <= S_START;
          end
        end
        S_OTHER: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!status.div_busy) begin
            state     <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (!plane && status.two_planes) begin
              plane <= 1'b1;
              state <= S_START;
            end else begin
              state    <= S_IDLE;
              in_ready <= 1'b1;
            end
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// File: rtl/frame_averager_even_odd_core.sv
// ----------------------------------------------------------------------------
// frame_averager_even_odd_core
// Accumulation frames: each pixel does a read-modify-write of the sum RAM
// through its registered read port; the next pixel is taken only after the
// write-back. Last frame: the 8-step divider runs for the even plane and, when
// both planes are averaged, again for the odd plane once the even average is
// taken. Synchronous reset returns the configuration to its defaults and
// clears the counters and the controller; the sum RAM is not cleared, the
// first frame of each plane overwrites its sums.
// ----------------------------------------------------------------------------
module frame_averager_even_odd_core #(
  parameter int MAX_PIXELS = 65536,
  parameter int MAX_FRAMES = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fae_pkg::CFG_DATA_W-1:0] cfg_data,
  fae_pixel_if.sink                      pix_in,
  fae_result_if.source                   res_out
);

  fae_pkg::fae_cmd_t    cmd;
  fae_pkg::fae_status_t status;
  fae_pkg::fae_result_t result;

  // sequencer
  fae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  fae_datapath #(
    .MAX_PIXELS (MAX_PIXELS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pix_in.pixel),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  // result payload
  assign res_out.plane       = result.plane;
  assign res_out.pixel_index = result.pixel_index;
  assign res_out.average     = result.average;
  assign res_out.run_last    = result.run_last;
  assign res_out.image_done  = result.image_done;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(res_out.valid && pix_in.ready))
    else $error("input ready while a result is pending");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.ready && res_out.run_last) |=> pix_in.ready)
    else $error("input not reopened after last result of a pixel");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> !pix_in.ready)
    else $error("input still ready after a transaction");

  a_div_done_on_out: assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> !status.div_busy)
    else $error("result shown while divider still iterating");

endmodule
